// ===== hdl/deferred_correction_stencil_assert.svh =====
// ----------------------------------------------------------------------------
// Deferred correction stencil assertion macros
// Shared property macros for the stencil modules. Each macro samples on the
// rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEFERRED_CORRECTION_STENCIL_ASSERT_SVH
`define DEFERRED_CORRECTION_STENCIL_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DCS_ASSERT(lbl, prop, msg)
`define DCS_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/dcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Deferred correction stencil package
// Widths, register codes and the types shared by the stencil modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcs_pkg;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 7;
    localparam int ROW_LEN     = 128;
    localparam int MAX_CELLS   = 16384;
    localparam int IDX_W       = 14;
    localparam int CORR_W      = 48;
    localparam int DIFF_W      = 33;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 68;
    localparam int SUM_W       = 66;
    localparam int ACC_W       = 100;
    localparam int FRAC_SHIFT  = 33;
    localparam int Q_W         = ACC_W - FRAC_SHIFT;
    localparam int POS_TOP     = 126;
    localparam int STEP_W      = 4;
    localparam int LAST_STEP   = 10;
    localparam int OUT_W       = 112;
    localparam int APB_AW      = 5;

    localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
    localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

    typedef enum logic [2:0] {
        REG_FLOW_X,
        REG_FLOW_Y,
        REG_AREA_W,
        REG_AREA_E,
        REG_AREA_S,
        REG_AREA_N,
        REG_ROWS,
        REG_COLS
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] flow_x_mag;
        logic [DATA_W-1:0] flow_y_mag;
        logic [DATA_W-1:0] area_w;
        logic [DATA_W-1:0] area_e;
        logic [DATA_W-1:0] area_s;
        logic [DATA_W-1:0] area_n;
        logic [POS_W-1:0]  rows;
        logic [POS_W-1:0]  cols;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         col;
        logic                     emit;
        logic [IDX_W-1:0]         idx;
        logic                     last;
    } item_t;

endpackage

// ===== hdl/deferred_correction_stencil.sv =====
// ----------------------------------------------------------------------------
// Deferred correction convection stencil
// Streams a ghost-padded grid in raster order and emits the deferred
// correction of every interior cell with its change from the last pass.
//
//   Channel  Dir  Payload (low bit first)                     Marker
//   s_       in   cell_value[31:0]                            -
//   m_       out  cell_index, new_correction, corr_change     tlast = pass_done
//   apb      in   eight registers at byte address 4*i         -
//
// A cell that emits nothing (ghost cells and the first two rows) only updates
// the line stores in the back end; an emitting interior cell also forms eight
// products on one shared 34x34 multiplier after the line store and correction
// memory reads.
// After reset a clearing pass zeroes all 16384 correction memory entries while
// s_tready stays low.
// A two-entry queue and the output register let either side stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deferred_correction_stencil_assert.svh"

module deferred_correction_stencil
    import dcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,    // cell_value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,    // cell_index, new_correction, correction_change
    output logic               m_tlast,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0]      flow_x_reg;
    logic [31:0]      flow_y_reg;
    logic [31:0]      area_w_reg;
    logic [31:0]      area_e_reg;
    logic [31:0]      area_s_reg;
    logic [31:0]      area_n_reg;
    logic [POS_W-1:0] rows_reg;
    logic [POS_W-1:0] cols_reg;

    cfg_t             cfg;
    reg_idx_t         reg_sel;
    logic             cfg_we;
    logic             clearing;
    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    item_t            push_item;
    item_t            head;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg.flow_x_mag = flow_x_reg[31] ? (~flow_x_reg + 32'd1) : flow_x_reg;
        cfg.flow_y_mag = flow_y_reg[31] ? (~flow_y_reg + 32'd1) : flow_y_reg;
        cfg.area_w     = area_w_reg;
        cfg.area_e     = area_e_reg;
        cfg.area_s     = area_s_reg;
        cfg.area_n     = area_n_reg;
        if (rows_reg == '0)
        begin
            cfg.rows = 7'd1;
        end
        else
        begin
            cfg.rows = (rows_reg > POS_W'(POS_TOP)) ? POS_W'(POS_TOP) : rows_reg;
        end
        if (cols_reg == '0)
        begin
            cfg.cols = 7'd1;
        end
        else
        begin
            cfg.cols = (cols_reg > POS_W'(POS_TOP)) ? POS_W'(POS_TOP) : cols_reg;
        end

        unique case (reg_sel)
            REG_FLOW_X: prdata = flow_x_reg;
            REG_FLOW_Y: prdata = flow_y_reg;
            REG_AREA_W: prdata = area_w_reg;
            REG_AREA_E: prdata = area_e_reg;
            REG_AREA_S: prdata = area_s_reg;
            REG_AREA_N: prdata = area_n_reg;
            REG_ROWS:   prdata = 32'(rows_reg);
            REG_COLS:   prdata = 32'(cols_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_x_reg <= '0;
            flow_y_reg <= '0;
            area_w_reg <= 32'h0001_0000;
            area_e_reg <= 32'h0001_0000;
            area_s_reg <= 32'h0001_0000;
            area_n_reg <= 32'h0001_0000;
            rows_reg   <= 7'd1;
            cols_reg   <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                REG_FLOW_X: flow_x_reg <= pwdata;
                REG_FLOW_Y: flow_y_reg <= pwdata;
                REG_AREA_W: area_w_reg <= pwdata;
                REG_AREA_E: area_e_reg <= pwdata;
                REG_AREA_S: area_s_reg <= pwdata;
                REG_AREA_N: area_n_reg <= pwdata;
                REG_ROWS:   rows_reg   <= pwdata[POS_W-1:0];
                REG_COLS:   cols_reg   <= pwdata[POS_W-1:0];
                default:    rows_reg   <= rows_reg;
            endcase
        end
    end

    dcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .hold      (clearing),
        .q_full    (q_full),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item)
    );

    dcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    dcs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_item   (head),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `DCS_NEVER(a_clear_blocks, clearing && s_tready, "Transfer allowed during clearing pass.")

endmodule

// ===== hdl/dcs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dcs_front.sv =====
// ----------------------------------------------------------------------------
// Stencil front end
// Accepts cell values, tracks the raster position and classifies each cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcs_front
    import dcs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     hold,
    input  logic                     q_full,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [DATA_W-1:0]        s_tdata,    // cell_value
    output logic                     push,
    output item_t                    push_item
);

    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_next;
    logic [POS_W-1:0] col_next;
    logic [POS_W:0]   rows_p1;
    logic [POS_W:0]   cols_p1;
    logic [POS_W:0]   cols_p2;
    logic [POS_W:0]   row_inc;
    logic [POS_W-1:0] row_m1;
    logic [IDX_W:0]   idx_full;

    assign s_tready = !hold && !q_full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        rows_p1  = {1'b0, cfg.rows} + 8'd1;
        cols_p1  = {1'b0, cfg.cols} + 8'd1;
        cols_p2  = {1'b0, cfg.cols} + 8'd2;
        row_inc  = {1'b0, row_reg} + 8'd1;
        row_m1   = row_reg - 7'd1;
        idx_full = (IDX_W+1)'(row_m1) * (IDX_W+1)'(cols_p2) + (IDX_W+1)'(col_reg);

        push_item.value = $signed(s_tdata);
        push_item.col   = col_reg;
        push_item.emit  = (row_reg >= 7'd2) && ({1'b0, row_reg} <= rows_p1) &&
                          (col_reg >= 7'd1) && (col_reg <= cfg.cols);
        push_item.idx   = idx_full[IDX_W-1:0];
        push_item.last  = ({1'b0, row_reg} == rows_p1) && (col_reg == cfg.cols);

        if ({1'b0, col_reg} >= cols_p1)
        begin
            col_next = '0;
            row_next = (row_inc > rows_p1) ? '0 : row_inc[POS_W-1:0];
        end
        else
        begin
            col_next = col_reg + 7'd1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (push)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// ===== hdl/dcs_queue.sv =====
// ----------------------------------------------------------------------------
// Stencil item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deferred_correction_stencil_assert.svh"

module dcs_queue
    import dcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  full,
    output logic  empty
);

    item_t      slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wptr_reg] <= push_item;
                wptr_reg           <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    `DCS_NEVER(a_q_overflow, push && full && !pop, "Queue written while full.")
    `DCS_NEVER(a_q_underflow, pop && empty, "Queue read while empty.")

endmodule

// ===== hdl/dcs_back.sv =====
// ----------------------------------------------------------------------------
// Stencil back end
// Reads the line stores, forms the four face corrections on a shared
// multiplier, rounds, saturates and delivers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deferred_correction_stencil_assert.svh"

module dcs_back
    import dcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              q_empty,
    input  item_t             q_item,
    output logic              pop,
    output logic              clearing,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                    state_reg;
    item_t                     item_reg;
    logic [IDX_W-1:0]          clear_cnt_reg;
    logic [STEP_W-1:0]         step_reg;
    logic [ROW_LEN-1:0]        older_vld_reg;
    logic [ROW_LEN-1:0]        newer_vld_reg;
    logic signed [DATA_W-1:0]  s_reg;
    logic signed [DATA_W-1:0]  p_reg;
    logic signed [DIFF_W-1:0]  dw_reg;
    logic signed [DIFF_W-1:0]  de_reg;
    logic signed [DIFF_W-1:0]  ds_reg;
    logic signed [DIFF_W-1:0]  dn_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   sx_reg;
    logic signed [SUM_W-1:0]   sy_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [CORR_W-1:0]  now_reg;
    logic signed [CORR_W-1:0]  prev_reg;
    logic signed [CORR_W-1:0]  change_reg;
    logic                      m_tvalid_reg;
    logic                      m_tlast_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    logic [DATA_W-1:0]         older_rdata;
    logic [DATA_W-1:0]         newer_rdata;
    logic [CORR_W-1:0]         corr_rdata;
    logic [POS_W-1:0]          col_up;
    logic [POS_W-1:0]          newer_raddr;
    logic                      line_we;
    logic                      corr_we;
    logic [IDX_W-1:0]          corr_waddr;
    logic [CORR_W-1:0]         corr_wdata;
    logic signed [DATA_W-1:0]  w_val;
    logic signed [DATA_W-1:0]  p_val;
    logic signed [DATA_W-1:0]  n_val;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [Q_W-1:0]     q_full;
    logic signed [CORR_W-1:0]  now_sat;
    logic signed [CORR_W:0]    diff;
    logic signed [CORR_W-1:0]  chg_sat;

    assign clearing    = (state_reg == ST_CLEAR);
    assign pop         = (state_reg == ST_IDLE) && !q_empty;
    assign col_up      = item_reg.col + 7'd1;
    assign newer_raddr = (state_reg == ST_FETCH) ? col_up : item_reg.col;
    assign line_we     = (state_reg == ST_FETCH);
    assign corr_we     = clearing ||
                         ((state_reg == ST_MUL) && (step_reg == STEP_W'(LAST_STEP)));
    assign corr_waddr  = clearing ? clear_cnt_reg : item_reg.idx;
    assign corr_wdata  = clearing ? '0 : now_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    dcs_ram #(.WIDTH(DATA_W), .DEPTH(ROW_LEN)) u_older (
        .clk   (clk),
        .we    (line_we),
        .waddr (item_reg.col),
        .wdata (p_val),
        .raddr (item_reg.col),
        .rdata (older_rdata)
    );

    dcs_ram #(.WIDTH(DATA_W), .DEPTH(ROW_LEN)) u_newer (
        .clk   (clk),
        .we    (line_we),
        .waddr (item_reg.col),
        .wdata (item_reg.value),
        .raddr (newer_raddr),
        .rdata (newer_rdata)
    );

    dcs_ram #(.WIDTH(CORR_W), .DEPTH(MAX_CELLS)) u_corr (
        .clk   (clk),
        .we    (corr_we),
        .waddr (corr_waddr),
        .wdata (corr_wdata),
        .raddr (item_reg.idx),
        .rdata (corr_rdata)
    );

    always_comb
    begin
        w_val = older_vld_reg[item_reg.col] ? $signed(older_rdata) : '0;
        p_val = newer_vld_reg[item_reg.col] ? $signed(newer_rdata) : '0;
        n_val = ((item_reg.col != POS_W'(ROW_LEN - 1)) && newer_vld_reg[col_up]) ?
                $signed(newer_rdata) : '0;

        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            4'd0:
            begin
                mul_a = $signed({2'b00, cfg.area_w});
                mul_b = MUL_W'(dw_reg);
            end
            4'd1:
            begin
                mul_a = $signed({2'b00, cfg.area_e});
                mul_b = MUL_W'(de_reg);
            end
            4'd2:
            begin
                mul_a = $signed({2'b00, cfg.area_s});
                mul_b = MUL_W'(ds_reg);
            end
            4'd3:
            begin
                mul_a = $signed({2'b00, cfg.area_n});
                mul_b = MUL_W'(dn_reg);
            end
            4'd4:
            begin
                mul_a = $signed({2'b00, cfg.flow_x_mag});
                mul_b = $signed({2'b00, sx_reg[31:0]});
            end
            4'd5:
            begin
                mul_a = $signed({2'b00, cfg.flow_x_mag});
                mul_b = $signed(sx_reg[SUM_W-1:32]);
            end
            4'd6:
            begin
                mul_a = $signed({2'b00, cfg.flow_y_mag});
                mul_b = $signed({2'b00, sy_reg[31:0]});
            end
            4'd7:
            begin
                mul_a = $signed({2'b00, cfg.flow_y_mag});
                mul_b = $signed(sy_reg[SUM_W-1:32]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        acc_rnd = $signed(acc_reg + ROUND_HALF);
        q_full  = Q_W'(acc_rnd >>> FRAC_SHIFT);
        if ((&q_full[Q_W-1:CORR_W-1]) || !(|q_full[Q_W-1:CORR_W-1]))
        begin
            now_sat = q_full[CORR_W-1:0];
        end
        else
        begin
            now_sat = q_full[Q_W-1] ? CORR_MIN : CORR_MAX;
        end

        diff = {now_reg[CORR_W-1], now_reg} - {prev_reg[CORR_W-1], prev_reg};
        if (diff[CORR_W] == diff[CORR_W-1])
        begin
            chg_sat = diff[CORR_W-1:0];
        end
        else
        begin
            chg_sat = diff[CORR_W] ? CORR_MIN : CORR_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            step_reg      <= '0;
            older_vld_reg <= '0;
            newer_vld_reg <= '0;
            s_reg         <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + 14'd1;
                    if (clear_cnt_reg == IDX_W'(MAX_CELLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        item_reg  <= q_item;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    dw_reg   <= DIFF_W'(w_val) - DIFF_W'(p_val);
                    de_reg   <= DIFF_W'(p_val) - DIFF_W'(item_reg.value);
                    ds_reg   <= DIFF_W'(s_reg) - DIFF_W'(p_val);
                    p_reg    <= p_val;
                    prev_reg <= $signed(corr_rdata);
                    s_reg    <= p_val;
                    older_vld_reg[item_reg.col] <= 1'b1;
                    newer_vld_reg[item_reg.col] <= 1'b1;
                    step_reg  <= '0;
                    state_reg <= item_reg.emit ? ST_MUL : ST_IDLE;
                end
                ST_MUL:
                begin
                    step_reg <= step_reg + 4'd1;
                    prod_reg <= mul_a * mul_b;
                    case (step_reg)
                        4'd0: dn_reg  <= DIFF_W'(p_reg) - DIFF_W'(n_val);
                        4'd1: sx_reg  <= SUM_W'(prod_reg);
                        4'd2: sx_reg  <= sx_reg + SUM_W'(prod_reg);
                        4'd3: sy_reg  <= SUM_W'(prod_reg);
                        4'd4: sy_reg  <= sy_reg + SUM_W'(prod_reg);
                        4'd5: acc_reg <= ACC_W'(prod_reg);
                        4'd6: acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< 32);
                        4'd7: acc_reg <= acc_reg + ACC_W'(prod_reg);
                        4'd8: acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< 32);
                        4'd9: now_reg <= now_sat;
                        4'd10:
                        begin
                            change_reg <= chg_sat;
                            state_reg  <= ST_OUT;
                        end
                        default:
                        begin
                            dn_reg <= dn_reg;
                        end
                    endcase
                end
                ST_OUT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= item_reg.last;
                        m_tdata_reg  <= {2'b00, change_reg, now_reg, item_reg.idx};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `DCS_NEVER(a_step_range, (state_reg == ST_MUL) && (step_reg > STEP_W'(LAST_STEP)), "Step out of range.")
    `DCS_ASSERT(a_out_load, (state_reg == ST_OUT) && !m_tvalid_reg |=> m_tvalid_reg, "Result not loaded.")

endmodule

// ===== sim/tb_deferred_correction_stencil.sv =====
// ----------------------------------------------------------------------------
// Deferred correction stencil testbench
// Streams ghost-padded grids through the stencil under several register
// settings and random handshake pressure, predicts each interior-cell
// correction, its change from the previous pass and the pass-done marker,
// and compares every output transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_deferred_correction_stencil;
    import dcs_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]  cell_index;
        logic [CORR_W-1:0] new_correction;
        logic [CORR_W-1:0] correction_change;
        logic              pass_done;
    } correction_t;

    localparam int HOLD_LEN = 300;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;    // cell_value
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // cell_index, new_correction, correction_change
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    deferred_correction_stencil DUT (.*);

    always #5 clk = ~clk;

    // Predictor state.
    logic [31:0]        reg_file [8];
    logic signed [31:0] older_row [ROW_LEN];
    logic signed [31:0] newer_row [ROW_LEN];
    logic signed [31:0] south_val;
    logic signed [47:0] stored_corr [MAX_CELLS];
    int unsigned        row_pos;
    int unsigned        col_pos;

    logic [31:0]        cell_queue [$];
    correction_t        expected_corrections [$];
    int                 errors = 0;
    int                 checked = 0;
    int                 sent = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    logic               hold_armed = 1'b0;
    int                 hold_count = 0;
    logic               holding;

    assign holding = hold_armed && (hold_count < HOLD_LEN);

    function automatic int unsigned clamp_size(logic [31:0] v);
        int unsigned s;
        s = v[6:0];
        if (s < 1) s = 1;
        if (s > POS_TOP) s = POS_TOP;
        return s;
    endfunction

    function automatic logic signed [47:0] sat48(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return CORR_MAX;
        if (v < -64'sh8000_0000_0000) return CORR_MIN;
        return v[47:0];
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] u);
        return u[31] ? (~u + 32'd1) : u;
    endfunction

    task automatic predict_cell(logic signed [31:0] value);
        int unsigned rows, cols, r, c, idx;
        logic signed [31:0] west, p, n;
        logic signed [199:0] acc, rounded;
        logic [63:0] fx, fy;
        logic signed [47:0] now, prev;
        correction_t e;
        rows = clamp_size(reg_file[REG_ROWS]);
        cols = clamp_size(reg_file[REG_COLS]);
        r = row_pos;
        c = col_pos;
        west = (c < ROW_LEN) ? older_row[c] : 0;
        p = (c < ROW_LEN) ? newer_row[c] : 0;
        n = (c + 1 < ROW_LEN) ? newer_row[c + 1] : 0;
        if (r >= 2 && r <= rows + 1 && c >= 1 && c <= cols) begin
            fx = mag32(reg_file[REG_FLOW_X]);
            fy = mag32(reg_file[REG_FLOW_Y]);
            acc = $signed({1'b0, fx * reg_file[REG_AREA_W]}) * (west - p)
                + $signed({1'b0, fx * reg_file[REG_AREA_E]}) * (p - value)
                + $signed({1'b0, fy * reg_file[REG_AREA_S]}) * (south_val - p)
                + $signed({1'b0, fy * reg_file[REG_AREA_N]}) * (p - n);
            rounded = (acc + (200'sd1 <<< 32)) >>> 33;
            if (rounded > 200'sh7FFF_FFFF_FFFF) now = CORR_MAX;
            else if (rounded < -200'sh8000_0000_0000) now = CORR_MIN;
            else now = rounded[47:0];
            idx = (r - 1) * (cols + 2) + c;
            prev = 0;
            if (idx < MAX_CELLS) begin
                prev = stored_corr[idx];
                stored_corr[idx] = now;
            end
            e.cell_index = idx[IDX_W-1:0];
            e.new_correction = now;
            e.correction_change = sat48(64'(now) - 64'(prev));
            e.pass_done = (r == rows + 1 && c == cols);
            expected_corrections.push_back(e);
        end
        if (c < ROW_LEN) begin
            older_row[c] = p;
            newer_row[c] = value;
        end
        south_val = p;
        if (c >= cols + 1) begin
            c = 0;
            r++;
            if (r > rows + 1) r = 0;
        end else begin
            c++;
        end
        row_pos = r & 7'h7F;
        col_pos = c & 7'h7F;
    endtask

    function automatic logic [31:0] random_cell(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    // Driver: offers the head of the pending queue, predicting on acceptance.
    always @(posedge clk) begin
        if (s_tvalid && s_tready) begin
            predict_cell($signed(s_tdata));
            void'(cell_queue.pop_front());
            sent++;
        end
    end

    always @(negedge clk) begin
        if (rst_n && cell_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata <= cell_queue[0];
        end else begin
            s_tvalid <= 1'b0;
        end
        if (holding) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= rst_n && ($urandom_range(1, 100) > recv_idle_pct);
        end
    end

    // Long receiver hold, counted in cycles.
    always @(negedge clk) begin
        if (holding) begin
            hold_count <= hold_count + 1;
        end
    end

    // Monitor.
    always @(posedge clk) begin
        correction_t e;
        if (m_tvalid && m_tready) begin
            if (expected_corrections.size() == 0) begin
                $display("%0t: unexpected transfer idx=%0d", $time, m_tdata[13:0]);
                errors++;
            end else begin
                e = expected_corrections.pop_front();
                checked++;
                if (m_tdata[13:0] !== e.cell_index) begin
                    $display("%0t: cell_index expected %0d actual %0d",
                             $time, e.cell_index, m_tdata[13:0]);
                    errors++;
                end
                if (m_tdata[61:14] !== e.new_correction) begin
                    $display("%0t: new_correction expected %h actual %h",
                             $time, e.new_correction, m_tdata[61:14]);
                    errors++;
                end
                if (m_tdata[109:62] !== e.correction_change) begin
                    $display("%0t: correction_change expected %h actual %h",
                             $time, e.correction_change, m_tdata[109:62]);
                    errors++;
                end
                if (m_tlast !== e.pass_done) begin
                    $display("%0t: pass_done expected %b actual %b",
                             $time, e.pass_done, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(reg_idx_t r, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_AW'(4 * int'(r));
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        reg_file[r] = v;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (cell_queue.size() > 0 || expected_corrections.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_grid(int rows, int cols, logic [31:0] fx, logic [31:0] fy);
        drain();
        write_reg(REG_FLOW_X, fx);
        write_reg(REG_FLOW_Y, fy);
        write_reg(REG_AREA_W, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 196608));
        write_reg(REG_AREA_E, $urandom_range(0, 3) == 0 ? 32'h0 : $urandom_range(0, 196608));
        write_reg(REG_AREA_S, $urandom_range(0, 196608));
        write_reg(REG_AREA_N, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 196608));
        write_reg(REG_ROWS, rows);
        write_reg(REG_COLS, cols);
    endtask

    task automatic queue_passes(int passes, int mode);
        int rows, cols;
        rows = clamp_size(reg_file[REG_ROWS]);
        cols = clamp_size(reg_file[REG_COLS]);
        repeat (passes)
            repeat ((rows + 2) * (cols + 2)) cell_queue.push_back(random_cell(mode));
    endtask

    initial begin
        for (int i = 0; i < 8; i++) reg_file[i] = (i >= 2 && i <= 5) ? 32'd65536 : 32'd0;
        reg_file[REG_ROWS] = 1;
        reg_file[REG_COLS] = 1;
        foreach (older_row[i]) begin
            older_row[i] = 0;
            newer_row[i] = 0;
        end
        foreach (stored_corr[i]) stored_corr[i] = 0;
        south_val = 0;
        row_pos = 0;
        col_pos = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: default 3x3 grid with extreme values, then extreme fluxes.
        cell_queue.push_back(32'h8000_0000);
        cell_queue.push_back(32'h7FFF_FFFF);
        cell_queue.push_back(32'hFFFF_FFFF);
        cell_queue.push_back(32'h0);
        cell_queue.push_back(32'h7FFF_FFFF);
        cell_queue.push_back(32'h8000_0000);
        cell_queue.push_back(32'h5555_AAAA);
        cell_queue.push_back(32'hAAAA_5555);
        cell_queue.push_back(32'h1);
        set_grid(1, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_passes(2, 2);
        set_grid(0, 0, 32'h0001_0000, 32'h0);
        queue_passes(1, 0);
        set_grid(127, 1, 32'hFFFF_0000, 32'h0000_8000);
        queue_passes(1, 1);

        send_idle_pct = 17;
        recv_idle_pct = 65;
        set_grid(6, 9, $urandom, $urandom);
        queue_passes(4, 1);
        hold_armed = 1'b1;
        set_grid(3, 4, $urandom_range(0, 131072), -$urandom_range(0, 131072));
        queue_passes(6, 1);

        send_idle_pct = 65;
        recv_idle_pct = 17;
        set_grid(5, 5, $urandom, $urandom);
        queue_passes(6, 0);
        set_grid(1, 127, 32'h7FFF_FFFF, $urandom);
        queue_passes(1, 2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_grid(4, 7, $urandom_range(0, 65536), $urandom_range(0, 65536));
        queue_passes(5, 1);
        drain();

        $display("Covered %0d cell transfers and %0d checked corrections across", sent, checked);
        $display("grid sizes from 1x1 to 126 wide, extreme fluxes and areas, and idle mixes.");
        if (errors == 0)
            $display("PASS deferred_correction_stencil");
        else
            $display("FAIL deferred_correction_stencil");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL deferred_correction_stencil");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dcs_pkg.sv
hdl/dcs_ram.sv
hdl/dcs_front.sv
hdl/dcs_queue.sv
hdl/dcs_back.sv
hdl/deferred_correction_stencil.sv
sim/tb_deferred_correction_stencil.sv
